// File: hw/rtl/cu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combination unranker package
// Shared widths, register indexes, status types and the saturated binomial
// function that fills the coefficient ROM.
// ----------------------------------------------------------------------------
package cu_pkg;

  localparam int RANK_W        = 30;
  localparam int VALUE_W       = 6;
  localparam int POS_W         = 4;
  localparam int SET_SIZE_W    = 6;
  localparam int SUBSET_SIZE_W = 5;
  localparam int FLOOR_W       = 5;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam int MAX_SET_DEF    = 32;
  localparam int MAX_SUBSET_DEF = 16;

  // Coefficients are clamped at 2**RANK_W, which already exceeds any rank.
  localparam int BINOM_W = RANK_W + 1;
  localparam logic [BINOM_W-1:0] BINOM_SAT = BINOM_W'(1) << RANK_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SUBSET_SIZE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LAST_INDEX = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BASED     = CFG_IDX_W'(3);

  // Status from the scan sequencer to the result emitter.
  typedef struct packed {
    logic done;
    logic keep;
  } scan_stat_t;

  // C(top, bot) clamped at BINOM_SAT, built row by row from Pascal's rule.
  function automatic logic [BINOM_W-1:0] binom_sat(input int top, input int bot);
    logic [BINOM_W-1:0] row [64];
    logic [BINOM_W:0]   sum;
    int                 r;
    int                 j;
    for (j = 0; j < 64; j++) begin
      row[j] = '0;
    end
    row[0] = BINOM_W'(1);
    for (r = 1; r <= top; r++) begin
      for (j = r; j >= 1; j--) begin
        sum = {1'b0, row[j]} + {1'b0, row[j-1]};
        if (sum > {1'b0, BINOM_SAT}) begin
          row[j] = BINOM_SAT;
        end else begin
          row[j] = sum[BINOM_W-1:0];
        end
      end
    end
    if (top < 0 || bot < 0 || bot > top) begin
      return '0;
    end
    return row[bot];
  endfunction

endpackage

// File: hw/rtl/cu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combination unranker channel interfaces
// Valid/ready channels for ranks, combination elements and register writes.
// ----------------------------------------------------------------------------
interface cu_in_if;
  logic                       valid;
  logic                       ready;
  logic [cu_pkg::RANK_W-1:0]  rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

interface cu_out_if;
  logic                        valid;
  logic                        ready;
  logic [cu_pkg::VALUE_W-1:0]  element_value;
  logic [cu_pkg::POS_W-1:0]    element_position;
  logic                        last_element;
  logic                        keep;

  modport source (output valid, output element_value, output element_position,
                  output last_element, output keep, input ready);
  modport sink   (input valid, input element_value, input element_position,
                  input last_element, input keep, output ready);
endinterface

interface cu_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cu_pkg::CFG_IDX_W-1:0]  index;
  logic [cu_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/combination_unranker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combination unranker
// Turns a lexicographic rank into the elements of its k-subset of n elements.
// ----------------------------------------------------------------------------
// A rank transfer starts a scan over candidate indices: a registered
// Pascal-table ROM read feeds one compare and subtract each cycle, and each
// position either subtracts and advances past an index or picks it. The
// elements then leave at one per cycle while the output is not stalled. The
// next rank is taken once the last element has entered the output register.
// Indices that run past n-1 saturate there; a set size or subset size of zero
// yields no elements.
// ----------------------------------------------------------------------------
module combination_unranker #(
  parameter int MAX_SET    = cu_pkg::MAX_SET_DEF,
  parameter int MAX_SUBSET = cu_pkg::MAX_SUBSET_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cu_in_if.sink      in_chan,
  cu_out_if.source   out_chan,
  cu_cfg_if.sink     cfg_chan
);

  localparam int SET_W = $clog2(MAX_SET + 1);
  localparam int SUB_W = $clog2(MAX_SUBSET + 1);
  localparam int TOP_W = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
  localparam int IDX_W = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;

  logic [cu_pkg::SET_SIZE_W-1:0]    set_size_r;
  logic [cu_pkg::SUBSET_SIZE_W-1:0] subset_size_r;
  logic [cu_pkg::FLOOR_W-1:0]       min_last_index_r;
  logic                             zero_based_r;

  logic [SET_W-1:0]   set_n;
  logic [SUB_W-1:0]   sub_k;
  logic               start;
  logic               scan_busy;
  logic               emit_busy;
  logic               pick_we;
  logic [IDX_W-1:0]   pick_idx;
  logic [TOP_W-1:0]   pick_val;
  logic [IDX_W-1:0]   last_pos;
  cu_pkg::scan_stat_t stat;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r       <= cu_pkg::SET_SIZE_W'(4);
      subset_size_r    <= cu_pkg::SUBSET_SIZE_W'(2);
      min_last_index_r <= '0;
      zero_based_r     <= 1'b0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        cu_pkg::CFG_SET_SIZE: begin
          set_size_r <= cfg_chan.data[cu_pkg::SET_SIZE_W-1:0];
        end
        cu_pkg::CFG_SUBSET_SIZE: begin
          subset_size_r <= cfg_chan.data[cu_pkg::SUBSET_SIZE_W-1:0];
        end
        cu_pkg::CFG_MIN_LAST_INDEX: begin
          min_last_index_r <= cfg_chan.data[cu_pkg::FLOOR_W-1:0];
        end
        cu_pkg::CFG_ZERO_BASED: begin
          zero_based_r <= cfg_chan.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Sizes above the build limits are clamped to them.
  assign set_n = (set_size_r > MAX_SET) ? SET_W'(MAX_SET) : SET_W'(set_size_r);
  assign sub_k = (subset_size_r > MAX_SUBSET) ? SUB_W'(MAX_SUBSET)
                                              : SUB_W'(subset_size_r);

  assign in_chan.ready = !scan_busy && !emit_busy;
  assign start = in_chan.valid && in_chan.ready && (set_n != '0) && (sub_k != '0);

  cu_scan #(
    .MAX_SET    (MAX_SET),
    .MAX_SUBSET (MAX_SUBSET)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .rank      (in_chan.rank),
    .set_n     (set_n),
    .sub_k     (sub_k),
    .floor_idx (min_last_index_r),
    .busy      (scan_busy),
    .pick_we   (pick_we),
    .pick_idx  (pick_idx),
    .pick_val  (pick_val),
    .last_pos  (last_pos),
    .stat      (stat)
  );

  cu_emit #(
    .MAX_SET    (MAX_SET),
    .MAX_SUBSET (MAX_SUBSET)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .pick_we    (pick_we),
    .pick_idx   (pick_idx),
    .pick_val   (pick_val),
    .last_pos   (last_pos),
    .stat       (stat),
    .zero_based (zero_based_r),
    .busy       (emit_busy),
    .out_chan   (out_chan)
  );

endmodule

// File: hw/rtl/cu_binom_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binomial coefficient ROM
// Pascal table C(top, bot), clamped above the rank range, with registered read.
// ----------------------------------------------------------------------------
module cu_binom_rom #(
  parameter int MAX_SET    = cu_pkg::MAX_SET_DEF,
  parameter int MAX_SUBSET = cu_pkg::MAX_SUBSET_DEF,
  localparam int TOP_W = (MAX_SET > 1) ? $clog2(MAX_SET) : 1,
  localparam int IDX_W = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1
) (
  input  logic                       clk,
  input  logic [TOP_W-1:0]           top,
  input  logic [IDX_W-1:0]           bot,
  input  logic                       blank,
  output logic [cu_pkg::BINOM_W-1:0] coef_r
);

  logic [cu_pkg::BINOM_W-1:0] rom [MAX_SET][MAX_SUBSET];

  for (genvar t = 0; t < MAX_SET; t++) begin : g_top
    for (genvar b = 0; b < MAX_SUBSET; b++) begin : g_bot
      assign rom[t][b] = cu_pkg::binom_sat(t, b);
    end
  end

  // A negative top or a position past the subset reads as zero, which forces a pick.
  always_ff @(posedge clk) begin
    if (blank) begin
      coef_r <= '0;
    end else begin
      coef_r <= rom[top][bot];
    end
  end

endmodule

// File: hw/rtl/cu_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combination unranker scan sequencer
// Walks candidate indices one per cycle: compare the ROM coefficient with the
// rank left, subtract and advance, or pick the index and move to the next one.
// ----------------------------------------------------------------------------
module cu_scan #(
  parameter int MAX_SET    = cu_pkg::MAX_SET_DEF,
  parameter int MAX_SUBSET = cu_pkg::MAX_SUBSET_DEF,
  localparam int SET_W = $clog2(MAX_SET + 1),
  localparam int SUB_W = $clog2(MAX_SUBSET + 1),
  localparam int TOP_W = (MAX_SET > 1) ? $clog2(MAX_SET) : 1,
  localparam int IDX_W = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cu_pkg::RANK_W-1:0]  rank,
  input  logic [SET_W-1:0]           set_n,
  input  logic [SUB_W-1:0]           sub_k,
  input  logic [cu_pkg::FLOOR_W-1:0] floor_idx,
  output logic                       busy,
  output logic                       pick_we,
  output logic [IDX_W-1:0]           pick_idx,
  output logic [TOP_W-1:0]           pick_val,
  output logic [IDX_W-1:0]           last_pos,
  output cu_pkg::scan_stat_t         stat
);

  localparam int CMP_W = (SET_W > cu_pkg::FLOOR_W) ? SET_W : cu_pkg::FLOOR_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PRIME = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [cu_pkg::RANK_W-1:0]  left_r, left_nxt;
  logic [SET_W-1:0]           x_r, x_nxt;
  logic [IDX_W-1:0]           i_r, i_nxt;
  logic [SET_W-1:0]           n_r, n_nxt;
  logic [IDX_W-1:0]           last_r, last_nxt;

  logic [cu_pkg::BINOM_W-1:0] coef_r;
  logic [SET_W-1:0]           pick;
  logic                       brk;
  logic                       keep;
  logic [TOP_W-1:0]           rom_top;
  logic [IDX_W-1:0]           rom_bot;
  logic                       rom_blank;

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    x_nxt     = x_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    last_nxt  = last_r;
    pick_we   = 1'b0;
    stat      = '0;
    pick      = (x_r >= n_r) ? n_r - 1'b1 : x_r;
    brk       = (coef_r == '0) || (coef_r > cu_pkg::BINOM_W'(left_r));
    keep      = (floor_idx == '0) || (CMP_W'(pick) >= CMP_W'(floor_idx));
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_PRIME;
          left_nxt  = rank;
          x_nxt     = '0;
          i_nxt     = '0;
          n_nxt     = set_n;
          last_nxt  = IDX_W'(sub_k - 1'b1);
        end
      end
      ST_PRIME: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!brk) begin
          left_nxt = left_r - coef_r[cu_pkg::RANK_W-1:0];
          x_nxt    = x_r + 1'b1;
        end else begin
          pick_we = 1'b1;
          if (i_r == last_r) begin
            stat.done = 1'b1;
            stat.keep = keep;
            state_nxt = ST_IDLE;
          end else begin
            x_nxt = pick + 1'b1;
            i_nxt = i_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The coefficient for the next candidate is fetched while this one is decided.
  // Both outcomes share the same top, so only the position part of the address waits
  // on the compare.
  assign rom_blank = (x_nxt >= n_r) || (i_nxt > last_r);
  assign rom_top   = TOP_W'(n_r - 1'b1 - x_nxt);
  assign rom_bot   = last_r - i_nxt;

  cu_binom_rom #(
    .MAX_SET    (MAX_SET),
    .MAX_SUBSET (MAX_SUBSET)
  ) u_rom (
    .clk    (clk),
    .top    (rom_top),
    .bot    (rom_bot),
    .blank  (rom_blank),
    .coef_r (coef_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      n_r     <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    x_r    <= x_nxt;
    i_r    <= i_nxt;
  end

  assign busy     = (state_r != ST_IDLE);
  assign pick_idx = i_r;
  assign pick_val = TOP_W'(pick);
  assign last_pos = last_r;

endmodule

// File: hw/rtl/cu_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combination unranker result emitter
// Holds the picked indices and sends them out in order through an output
// register, one element per transfer.
// ----------------------------------------------------------------------------
module cu_emit #(
  parameter int MAX_SET    = cu_pkg::MAX_SET_DEF,
  parameter int MAX_SUBSET = cu_pkg::MAX_SUBSET_DEF,
  localparam int TOP_W = (MAX_SET > 1) ? $clog2(MAX_SET) : 1,
  localparam int IDX_W = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pick_we,
  input  logic [IDX_W-1:0]   pick_idx,
  input  logic [TOP_W-1:0]   pick_val,
  input  logic [IDX_W-1:0]   last_pos,
  input  cu_pkg::scan_stat_t stat,
  input  logic               zero_based,
  output logic               busy,
  cu_out_if.source           out_chan
);

  logic [TOP_W-1:0]            picks_r [MAX_SUBSET];
  logic                        active_r;
  logic [IDX_W-1:0]            e_r;
  logic                        keep_r;
  logic                        valid_r;
  logic [cu_pkg::VALUE_W-1:0]  value_r;
  logic [cu_pkg::POS_W-1:0]    pos_r;
  logic                        last_r;
  logic                        okeep_r;
  logic                        load;
  logic                        at_last;

  assign load    = active_r && (!valid_r || out_chan.ready);
  assign at_last = (e_r == last_pos);

  always_ff @(posedge clk) begin
    if (pick_we) begin
      picks_r[pick_idx] <= pick_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      if (stat.done) begin
        active_r <= 1'b1;
      end else if (load && at_last) begin
        active_r <= 1'b0;
      end
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      e_r    <= '0;
      keep_r <= stat.keep;
    end else if (load && !at_last) begin
      e_r <= e_r + 1'b1;
    end
    if (load) begin
      value_r <= cu_pkg::VALUE_W'(picks_r[e_r])
               + {{(cu_pkg::VALUE_W-1){1'b0}}, ~zero_based};
      pos_r   <= cu_pkg::POS_W'(e_r);
      last_r  <= at_last;
      okeep_r <= keep_r;
    end
  end

  // The emitter frees up once the final element sits in the output register.
  assign busy                      = active_r;
  assign out_chan.valid            = valid_r;
  assign out_chan.element_value    = value_r;
  assign out_chan.element_position = pos_r;
  assign out_chan.last_element     = last_r;
  assign out_chan.keep             = okeep_r;

endmodule

// File: hw/rtl/cu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combination unranker port checker
// Watches the top-level channels for ordering and hold rules over time.
// ----------------------------------------------------------------------------
module cu_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [cu_pkg::VALUE_W-1:0] out_value,
  input logic [cu_pkg::POS_W-1:0]   out_pos,
  input logic                       out_last,
  input logic                       out_keep
);

  logic mid_xfer;

  assign mid_xfer = out_valid && out_ready && !out_last;

  // A stalled element must hold still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable({out_value, out_pos, out_last, out_keep}))
    else $error("output element changed while stalled");

  // Within one combination the next element follows at once, one position on,
  // with the same keep flag and a value that does not drop.
  a_next_elem: assert property (@(posedge clk) disable iff (!rst_n)
    mid_xfer |=> out_valid && out_keep == $past(out_keep)
      && out_pos == $past(out_pos) + 1'b1 && out_value >= $past(out_value))
    else $error("combination element sequence broken");

  // No new rank is taken while a combination is still going out.
  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    mid_xfer |-> !in_ready)
    else $error("rank taken in the middle of a combination");

  // The scan runs through its prime and scan states first, so no element appears right after a rank transfer.
  a_scan_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("element appeared directly after a rank transfer");

endmodule

bind combination_unranker cu_checker u_cu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_value (out_chan.element_value),
  .out_pos   (out_chan.element_position),
  .out_last  (out_chan.last_element),
  .out_keep  (out_chan.keep)
);
